// ----- rtl/core/cdtu_pkg.sv -----
package cdtu_pkg;

    // instruction codes
    localparam logic [3:0] OP_MOV  = 4'd0;
    localparam logic [3:0] OP_MVI  = 4'd1;
    localparam logic [3:0] OP_LDA  = 4'd2;
    localparam logic [3:0] OP_STA  = 4'd3;
    localparam logic [3:0] OP_LHLD = 4'd4;
    localparam logic [3:0] OP_SHLD = 4'd5;
    localparam logic [3:0] OP_LXI  = 4'd6;
    localparam logic [3:0] OP_XCHG = 4'd7;
    localparam logic [3:0] OP_STAX = 4'd8;

    // register codes
    localparam logic [2:0] REG_A  = 3'd0;
    localparam logic [2:0] REG_B  = 3'd1;
    localparam logic [2:0] REG_C  = 3'd2;
    localparam logic [2:0] REG_D  = 3'd3;
    localparam logic [2:0] REG_E  = 3'd4;
    localparam logic [2:0] REG_H  = 3'd5;
    localparam logic [2:0] REG_L  = 3'd6;
    localparam logic [2:0] CODE_M = 3'd7;

    // register pair codes
    localparam logic [1:0] PAIR_BC = 2'd0;
    localparam logic [1:0] PAIR_DE = 2'd1;
    localparam logic [1:0] PAIR_HL = 2'd2;
    localparam logic [1:0] PAIR_SP = 2'd3;

    // status codes
    localparam logic STAT_DONE    = 1'b0;
    localparam logic STAT_INVALID = 1'b1;

    // request from the execution unit to the data memory port
    typedef struct packed {
        logic        en;
        logic        we;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } mem_req_t;

endpackage

// ----- rtl/core/cdtu_mem.sv -----
module cdtu_mem
    import cdtu_pkg::*;
#(
    parameter int ADDR_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [7:0]           wdata,
    output logic [7:0]           rdata
);

    logic [7:0] mem_array [0:(1 << ADDR_BITS)-1];
    logic [7:0] rdata_reg;

    // single-port byte memory, registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_array[addr] <= wdata;
            end
            rdata_reg <= mem_array[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/cdtu_exec.sv -----
module cdtu_exec
    import cdtu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        mem_ready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  operation,
    input  logic [2:0]  dest_reg,
    input  logic [2:0]  src_reg,
    input  logic [7:0]  imm_data,
    input  logic [15:0] address,
    input  logic [1:0]  pair_sel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status,
    output logic [7:0]  acc_value,
    output logic [15:0] pair_bc,
    output logic [15:0] pair_de,
    output logic [15:0] pair_hl,
    output logic [15:0] stack_ptr,
    output mem_req_t    mem_req,
    input  logic [7:0]  mem_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_WR2
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  regs_reg [0:6];
    logic [7:0]  regs_next [0:6];
    logic [15:0] sp_reg, sp_next;
    logic [2:0]  ld_dst_reg, ld_dst_next;
    logic        lhld_reg, lhld_next;
    logic [15:0] addr2_reg, addr2_next;
    logic        out_valid_reg, out_valid_next;
    logic        status_reg;
    logic [7:0]  acc_reg;
    logic [15:0] bc_reg, de_reg, hl_reg, sp_out_reg;
    logic        status_c;
    logic        out_load;
    logic        accept;
    logic [15:0] hl_addr;
    logic [15:0] bc_addr;
    logic [15:0] de_addr;

    assign in_ready = (state_reg == S_IDLE) && mem_ready && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign hl_addr  = {regs_reg[REG_H], regs_reg[REG_L]};
    assign bc_addr  = {regs_reg[REG_B], regs_reg[REG_C]};
    assign de_addr  = {regs_reg[REG_D], regs_reg[REG_E]};

    // instruction decode and memory sequencing
    always_comb
    begin
        state_next  = state_reg;
        regs_next   = regs_reg;
        sp_next     = sp_reg;
        ld_dst_next = ld_dst_reg;
        lhld_next   = lhld_reg;
        addr2_next  = addr2_reg;
        status_c    = STAT_DONE;
        out_load    = 1'b0;
        mem_req     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    addr2_next = address + 16'd1;
                    lhld_next  = 1'b0;
                    unique case (operation)
                        OP_MOV:
                        begin
                            if (dest_reg == CODE_M && src_reg == CODE_M)
                            begin
                                status_c = STAT_INVALID;
                                out_load = 1'b1;
                            end
                            else if (dest_reg == CODE_M)
                            begin
                                mem_req.en    = 1'b1;
                                mem_req.we    = 1'b1;
                                mem_req.addr  = hl_addr;
                                mem_req.wdata = regs_reg[src_reg];
                                out_load      = 1'b1;
                            end
                            else if (src_reg == CODE_M)
                            begin
                                mem_req.en   = 1'b1;
                                mem_req.addr = hl_addr;
                                ld_dst_next  = dest_reg;
                                state_next   = S_RD1;
                            end
                            else
                            begin
                                regs_next[dest_reg] = regs_reg[src_reg];
                                out_load            = 1'b1;
                            end
                        end
                        OP_MVI:
                        begin
                            if (dest_reg == CODE_M)
                            begin
                                mem_req.en    = 1'b1;
                                mem_req.we    = 1'b1;
                                mem_req.addr  = hl_addr;
                                mem_req.wdata = imm_data;
                            end
                            else
                            begin
                                regs_next[dest_reg] = imm_data;
                            end
                            out_load = 1'b1;
                        end
                        OP_LDA:
                        begin
                            mem_req.en   = 1'b1;
                            mem_req.addr = address;
                            ld_dst_next  = REG_A;
                            state_next   = S_RD1;
                        end
                        OP_STA:
                        begin
                            mem_req.en    = 1'b1;
                            mem_req.we    = 1'b1;
                            mem_req.addr  = address;
                            mem_req.wdata = regs_reg[REG_A];
                            out_load      = 1'b1;
                        end
                        OP_LHLD:
                        begin
                            mem_req.en   = 1'b1;
                            mem_req.addr = address;
                            ld_dst_next  = REG_L;
                            lhld_next    = 1'b1;
                            state_next   = S_RD1;
                        end
                        OP_SHLD:
                        begin
                            mem_req.en    = 1'b1;
                            mem_req.we    = 1'b1;
                            mem_req.addr  = address;
                            mem_req.wdata = regs_reg[REG_L];
                            out_load      = 1'b1;
                            state_next    = S_WR2;
                        end
                        OP_LXI:
                        begin
                            unique case (pair_sel)
                                PAIR_BC:
                                begin
                                    regs_next[REG_B] = address[15:8];
                                    regs_next[REG_C] = address[7:0];
                                end
                                PAIR_DE:
                                begin
                                    regs_next[REG_D] = address[15:8];
                                    regs_next[REG_E] = address[7:0];
                                end
                                PAIR_HL:
                                begin
                                    regs_next[REG_H] = address[15:8];
                                    regs_next[REG_L] = address[7:0];
                                end
                                PAIR_SP:
                                begin
                                    sp_next = address;
                                end
                            endcase
                            out_load = 1'b1;
                        end
                        OP_XCHG:
                        begin
                            regs_next[REG_D] = regs_reg[REG_H];
                            regs_next[REG_H] = regs_reg[REG_D];
                            regs_next[REG_E] = regs_reg[REG_L];
                            regs_next[REG_L] = regs_reg[REG_E];
                            out_load         = 1'b1;
                        end
                        OP_STAX:
                        begin
                            if (pair_sel == PAIR_BC || pair_sel == PAIR_DE)
                            begin
                                mem_req.en    = 1'b1;
                                mem_req.we    = 1'b1;
                                mem_req.addr  = (pair_sel == PAIR_BC) ? bc_addr : de_addr;
                                mem_req.wdata = regs_reg[REG_A];
                            end
                            else
                            begin
                                status_c = STAT_INVALID;
                            end
                            out_load = 1'b1;
                        end
                        default:
                        begin
                            status_c = STAT_INVALID;
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_RD1:
            begin
                regs_next[ld_dst_reg] = mem_rdata;
                if (lhld_reg)
                begin
                    mem_req.en   = 1'b1;
                    mem_req.addr = addr2_reg;
                    state_next   = S_RD2;
                end
                else
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RD2:
            begin
                regs_next[REG_H] = mem_rdata;
                out_load         = 1'b1;
                state_next       = S_IDLE;
            end
            S_WR2:
            begin
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = addr2_reg;
                mem_req.wdata = regs_reg[REG_H];
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    // state, architectural registers and result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int i = 0; i < 7; i++)
            begin
                regs_reg[i] <= 8'd0;
            end
            sp_reg        <= 16'd0;
            ld_dst_reg    <= REG_A;
            lhld_reg      <= 1'b0;
            addr2_reg     <= 16'd0;
            out_valid_reg <= 1'b0;
            status_reg    <= STAT_DONE;
            acc_reg       <= 8'd0;
            bc_reg        <= 16'd0;
            de_reg        <= 16'd0;
            hl_reg        <= 16'd0;
            sp_out_reg    <= 16'd0;
        end
        else
        begin
            state_reg     <= state_next;
            regs_reg      <= regs_next;
            sp_reg        <= sp_next;
            ld_dst_reg    <= ld_dst_next;
            lhld_reg      <= lhld_next;
            addr2_reg     <= addr2_next;
            out_valid_reg <= out_valid_next;
            if (out_load)
            begin
                status_reg <= status_c;
                acc_reg    <= regs_next[REG_A];
                bc_reg     <= {regs_next[REG_B], regs_next[REG_C]};
                de_reg     <= {regs_next[REG_D], regs_next[REG_E]};
                hl_reg     <= {regs_next[REG_H], regs_next[REG_L]};
                sp_out_reg <= sp_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign acc_value = acc_reg;
    assign pair_bc   = bc_reg;
    assign pair_de   = de_reg;
    assign pair_hl   = hl_reg;
    assign stack_ptr = sp_out_reg;

    // a result word is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("result word overwritten");

    // no new word while a memory sequence is in flight
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input taken during memory sequence");

    // second load byte always produces a result
    a_rd2_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD2) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("lhld finished without result");

    // a read phase never issues a write
    a_rd_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD1 || state_reg == S_RD2) |-> !mem_req.we)
        else $error("write issued during read phase");

endmodule

// ----- rtl/core/cpu_data_transfer_unit.sv -----
// MOV/MVI/STA/STAX/LXI/XCHG/SHLD register their result word on acceptance, MOV r,M and
// LDA after the read in S_RD1, LHLD after those in S_RD1 and S_RD2 (one registered read
// of the byte memory per byte). 1 word per cycle for register and single-write ops while
// out_ready is high; in_ready stays low in S_RD1 (MOV r,M, LDA, LHLD), S_RD2 (LHLD) and
// S_WR2 (SHLD), as the memory port is single. Reset clears A..L and SP at once, then a
// clearing pass zeroes all 2^ADDR_BITS memory bytes, one per cycle, with in_ready low.
module cpu_data_transfer_unit
    import cdtu_pkg::*;
#(
    parameter int ADDR_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  operation,
    input  logic [2:0]  dest_reg,
    input  logic [2:0]  src_reg,
    input  logic [7:0]  imm_data,
    input  logic [15:0] address,
    input  logic [1:0]  pair_sel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status,
    output logic [7:0]  acc_value,
    output logic [15:0] pair_bc,
    output logic [15:0] pair_de,
    output logic [15:0] pair_hl,
    output logic [15:0] stack_ptr
);

    localparam logic [ADDR_BITS-1:0] LAST_ADDR = {ADDR_BITS{1'b1}};

    logic                 clr_busy_reg, clr_busy_next;
    logic [ADDR_BITS-1:0] clr_addr_reg, clr_addr_next;
    mem_req_t             exec_req;
    logic                 mem_en;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_addr;
    logic [7:0]           mem_wdata;
    logic [7:0]           mem_rdata;

    // clearing sweep after reset
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_BITS'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // memory port select: sweep first, then execution unit
    always_comb
    begin
        if (clr_busy_reg)
        begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = clr_addr_reg;
            mem_wdata = 8'd0;
        end
        else
        begin
            mem_en    = exec_req.en;
            mem_we    = exec_req.we;
            mem_addr  = exec_req.addr[ADDR_BITS-1:0];
            mem_wdata = exec_req.wdata;
        end
    end

    cdtu_mem #(
        .ADDR_BITS (ADDR_BITS)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    cdtu_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .mem_ready (!clr_busy_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .dest_reg  (dest_reg),
        .src_reg   (src_reg),
        .imm_data  (imm_data),
        .address   (address),
        .pair_sel  (pair_sel),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .acc_value (acc_value),
        .pair_bc   (pair_bc),
        .pair_de   (pair_de),
        .pair_hl   (pair_hl),
        .stack_ptr (stack_ptr),
        .mem_req   (exec_req),
        .mem_rdata (mem_rdata)
    );

    // nothing enters while the memory is being cleared
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !in_ready)
        else $error("word accepted during memory clear");

endmodule
